[hw/rtl/eebs_pkg.sv]
// Package for the eligible entry best select block: table size, widths,
// operation/criterion/status codes, entry layout and scan control structs.
// No dependencies.
package eebs_pkg;

  localparam int MaxEntries = 64;
  localparam int IdxW       = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int CntW       = $clog2(MaxEntries + 1);

  localparam int IndexW   = 6;
  localparam int QualityW = 16;
  localparam int SpeedW   = 16;
  localparam int PriceW   = 24;

  typedef enum logic [1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_MARK   = 2'd1,
    FUNC_SELECT = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    GOAL_PRICE   = 2'd0,
    GOAL_SPEED   = 2'd1,
    GOAL_QUALITY = 2'd2,
    GOAL_FIRST   = 2'd3
  } goal_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_NONE = 2'd1,
    STAT_FULL = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [PriceW-1:0]   price;
    logic [SpeedW-1:0]   speed;
    logic [QualityW-1:0] quality;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  // Control from the sequencer to the compare unit
  typedef struct packed {
    logic            clr;
    logic            vld;
    logic [IdxW-1:0] idx;
  } scan_ctl_t;

  // Running result of the compare unit
  typedef struct packed {
    logic            found;
    logic [IdxW-1:0] idx;
  } scan_res_t;

endpackage

[hw/rtl/eebs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module eebs_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/eebs_cmp.sv]
// Shared compare unit: checks one entry per cycle for eligibility and keeps
// the best entry seen so far. Depends on eebs_pkg.
module eebs_cmp
  import eebs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  scan_ctl_t         ctl_i,
  input  entry_t            entry_i,
  input  logic              busy_i,
  input  goal_e             goal_i,
  input  logic [PriceW-1:0] budget_i,
  output scan_res_t         res_o
);

  logic   found_q, found_d;
  logic   [IdxW-1:0] idx_q, idx_d;
  entry_t best_q, best_d;
  logic   eligible;
  logic   beats;

  assign eligible = !busy_i && (entry_i.price <= budget_i);

  always_comb begin
    case (goal_i)
      GOAL_PRICE:   beats = entry_i.price < best_q.price;
      GOAL_SPEED:   beats = entry_i.speed > best_q.speed;
      GOAL_QUALITY: beats = entry_i.quality > best_q.quality;
      default:      beats = 1'b0;
    endcase
  end

  always_comb begin
    found_d = found_q;
    idx_d   = idx_q;
    best_d  = best_q;
    if (ctl_i.clr) begin
      found_d = 1'b0;
    end else if (ctl_i.vld && eligible && (!found_q || beats)) begin
      // strict compare keeps the earliest index on ties
      found_d = 1'b1;
      idx_d   = ctl_i.idx;
      best_d  = entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    best_q <= best_d;
  end

  assign res_o.found = found_q;
  assign res_o.idx   = idx_q;

endmodule

[hw/rtl/eligible_entry_best_select.sv]
// Top level of the eligible entry best select block: sequencer, entry and
// busy-mark RAMs, shared compare unit and output register.
// Depends on eebs_pkg, eebs_ram and eebs_cmp.
//
// Usage: one request transaction on the s_axis side gives exactly one
// response transaction on the m_axis side. tuser carries the operation code
// (load, mark, select, clear) in and the status out.
// Load, mark and clear finish in the accept cycle; the response is valid in
// the next cycle. A select walks the loaded entries through the compare unit,
// one entry per cycle out of the RAM read port, and its response is
// registered once the last entry has passed the compare unit; an empty
// table skips the scan. No request is taken during a select scan.
// The output register lets a new request be accepted in the cycle the
// previous response is taken; while the receiver stalls, the response holds
// and new requests wait once it is full.
// Reset empties the table (entry count to zero) and drops any pending
// response; the RAM contents are not cleared, and only loaded entries are
// ever compared.
module eligible_entry_best_select
  import eebs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [5:0] entry_index, [6] busy_value, [22:7] quality_in, [38:23] speed_in,
  // [62:39] price_in, [64:63] criterion, [88:65] budget, [95:89] zero
  input  logic [95:0] s_axis_tdata_i,
  // [1:0] func
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [5:0] chosen_index, [7:6] zero
  output logic [7:0]  m_axis_tdata_o,
  // [1:0] status
  output logic [1:0]  m_axis_tuser_o
);

  // Request fields
  func_e               func;
  logic [IndexW-1:0]   entry_index;
  logic                busy_value;
  entry_t              new_entry;
  goal_e               criterion;
  logic [PriceW-1:0]   budget;

  assign func              = func_e'(s_axis_tuser_i);
  assign entry_index       = s_axis_tdata_i[5:0];
  assign busy_value        = s_axis_tdata_i[6];
  assign new_entry.quality = s_axis_tdata_i[22:7];
  assign new_entry.speed   = s_axis_tdata_i[38:23];
  assign new_entry.price   = s_axis_tdata_i[62:39];
  assign criterion         = goal_e'(s_axis_tdata_i[64:63]);
  assign budget            = s_axis_tdata_i[88:65];

  state_e            state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [CntW-1:0]   ptr_q, ptr_d;
  logic              rd_vld_q;
  logic [IdxW-1:0]   rd_idx_q;
  goal_e             goal_q;
  logic [PriceW-1:0] budget_q;

  logic              out_vld_q, out_vld_d;
  status_e           out_stat_q, out_stat_d;
  logic [IndexW-1:0] out_idx_q, out_idx_d;

  logic              in_ready;
  logic              accept;
  logic              scan_last;
  logic              out_free;
  logic              done_load;
  logic              table_full;
  logic              mark_ok;

  logic              ent_we;
  logic              busy_we;
  logic [IdxW-1:0]   busy_waddr;
  logic              busy_wdata;
  entry_t            rd_entry;
  logic              rd_busy;

  scan_ctl_t         scan_ctl;
  scan_res_t         scan_res;

  assign out_free   = !out_vld_q || m_axis_tready_i;
  assign accept     = s_axis_tvalid_i && in_ready;
  assign scan_last  = (ptr_q + CntW'(1)) == count_q;
  assign table_full = 32'(count_q) >= 32'(MaxEntries);
  assign mark_ok    = 32'(entry_index) < 32'(MaxEntries);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (func == FUNC_SELECT)) begin
          state_d = (count_q == '0) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    done_load = 1'b0;
    case (state_q)
      ST_IDLE: in_ready  = out_free;
      ST_DONE: done_load = out_free;
      default: begin
        in_ready  = 1'b0;
        done_load = 1'b0;
      end
    endcase
  end

  // Table writes, counters and response selection
  always_comb begin
    count_d    = count_q;
    ptr_d      = ptr_q;
    ent_we     = 1'b0;
    busy_we    = 1'b0;
    busy_waddr = count_q[IdxW-1:0];
    busy_wdata = 1'b0;
    out_stat_d = out_stat_q;
    out_idx_d  = out_idx_q;
    out_vld_d  = m_axis_tready_i ? 1'b0 : out_vld_q;

    if (state_q == ST_SCAN) begin
      ptr_d = ptr_q + CntW'(1);
    end

    if (accept) begin
      ptr_d = '0;
      case (func)
        FUNC_LOAD: begin
          out_vld_d = 1'b1;
          if (table_full) begin
            out_stat_d = STAT_FULL;
            out_idx_d  = '0;
          end else begin
            ent_we     = 1'b1;
            busy_we    = 1'b1;
            out_stat_d = STAT_OK;
            out_idx_d  = IndexW'(count_q);
            count_d    = count_q + CntW'(1);
          end
        end
        FUNC_MARK: begin
          out_vld_d  = 1'b1;
          busy_we    = mark_ok;
          busy_waddr = IdxW'(entry_index);
          busy_wdata = busy_value;
          out_stat_d = STAT_OK;
          out_idx_d  = entry_index;
        end
        FUNC_CLEAR: begin
          out_vld_d  = 1'b1;
          count_d    = '0;
          out_stat_d = STAT_OK;
          out_idx_d  = '0;
        end
        default: begin
          // select: response comes after the scan
          out_vld_d = out_vld_d;
        end
      endcase
    end

    if (done_load) begin
      out_vld_d  = 1'b1;
      out_stat_d = scan_res.found ? STAT_OK : STAT_NONE;
      out_idx_d  = scan_res.found ? IndexW'(scan_res.idx) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      ptr_q     <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      ptr_q     <= ptr_d;
      rd_vld_q  <= (state_q == ST_SCAN);
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q   <= ptr_q[IdxW-1:0];
    out_stat_q <= out_stat_d;
    out_idx_q  <= out_idx_d;
    if (accept) begin
      goal_q   <= criterion;
      budget_q <= budget;
    end
  end

  eebs_ram #(
    .Width (EntryW),
    .Depth (MaxEntries)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (count_q[IdxW-1:0]),
    .wdata_i (new_entry),
    .raddr_i (ptr_q[IdxW-1:0]),
    .rdata_o (rd_entry)
  );

  eebs_ram #(
    .Width (1),
    .Depth (MaxEntries)
  ) u_busy_ram (
    .clk_i   (clk_i),
    .we_i    (busy_we),
    .waddr_i (busy_waddr),
    .wdata_i (busy_wdata),
    .raddr_i (ptr_q[IdxW-1:0]),
    .rdata_o (rd_busy)
  );

  assign scan_ctl.clr = accept;
  assign scan_ctl.vld = rd_vld_q;
  assign scan_ctl.idx = rd_idx_q;

  eebs_cmp u_cmp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (scan_ctl),
    .entry_i  (rd_entry),
    .busy_i   (rd_busy),
    .goal_i   (goal_q),
    .budget_i (budget_q),
    .res_o    (scan_res)
  );

  assign s_axis_tready_o = in_ready;
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {2'b00, out_idx_q};
  assign m_axis_tuser_o  = out_stat_q;

endmodule

[bench/eligible_entry_best_select_tb.sv]
// Testbench for eligible_entry_best_select: directed table, then random
// load/mark/select/clear sequences checked against an in-bench predictor.
// Depends on eebs_pkg and the eligible_entry_best_select RTL.
module eligible_entry_best_select_tb
  import eebs_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomItems  = 800;
  localparam int unsigned DrainCycles  = 70;    // covers the longest select scan
  localparam int unsigned WatchdogMax  = 2000;
  localparam logic [PriceW-1:0] PriceMax = '1;

  typedef struct packed {
    func_e                func;
    logic [IndexW-1:0]    index;
    logic                 busy;
    logic [QualityW-1:0]  quality;
    logic [SpeedW-1:0]    speed;
    logic [PriceW-1:0]    price;
    goal_e                goal;
    logic [PriceW-1:0]    budget;
  } request_t;

  typedef struct packed {
    status_e           status;
    logic [IndexW-1:0] index;
  } pick_t;

  typedef struct {
    func_e               func;
    logic [IndexW-1:0]   index;
    logic                busy;
    logic [QualityW-1:0] quality;
    logic [SpeedW-1:0]   speed;
    logic [PriceW-1:0]   price;
    goal_e               goal;
    logic [PriceW-1:0]   budget;
    bit                  typed;
    status_e             status;
    logic [IndexW-1:0]   chosen;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_valid;
  logic [95:0] s_data;
  logic [1:0]  s_func;
  logic        m_ready;
  logic        s_ready;
  logic        m_valid;
  logic [7:0]  m_data;
  logic [1:0]  m_status;

  // Predictor state
  logic [QualityW-1:0] quality_tab [MaxEntries];
  logic [SpeedW-1:0]   speed_tab   [MaxEntries];
  logic [PriceW-1:0]   price_tab   [MaxEntries];
  bit                  busy_tab    [MaxEntries];
  int unsigned         loaded;

  pick_t       pending_picks[$];
  int unsigned mismatches;
  int unsigned sent;
  bit          no_idle;

  eligible_entry_best_select u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_func),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_status)
  );

  initial forever #5 clk_i = ~clk_i;

  dir_row_t dir_rows [] = '{
    '{FUNC_SELECT, 6'd0,  1'b0, 16'h0000, 16'h0000, 24'h000000, GOAL_PRICE,   24'hFFFFFF,
      1'b1, STAT_NONE, 6'd0},
    '{FUNC_SELECT, 6'd0,  1'b0, 16'h0000, 16'h0000, 24'h000000, GOAL_FIRST,   24'h000000,
      1'b1, STAT_NONE, 6'd0},
    '{FUNC_CLEAR,  6'd0,  1'b0, 16'h0000, 16'h0000, 24'h000000, GOAL_PRICE,   24'h000000,
      1'b1, STAT_OK,   6'd0},
    '{FUNC_MARK,   6'd63, 1'b1, 16'h0000, 16'h0000, 24'h000000, GOAL_PRICE,   24'h000000,
      1'b1, STAT_OK,   6'd63},
    '{FUNC_MARK,   6'd0,  1'b0, 16'h0000, 16'h0000, 24'h000000, GOAL_PRICE,   24'h000000,
      1'b1, STAT_OK,   6'd0},
    '{FUNC_LOAD,   6'd0,  1'b0, 16'h0000, 16'h0000, 24'h000000, GOAL_PRICE,   24'h000000,
      1'b1, STAT_OK,   6'd0},
    '{FUNC_LOAD,   6'd0,  1'b0, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, GOAL_PRICE,   24'h000000,
      1'b1, STAT_OK,   6'd1},
    '{FUNC_LOAD,   6'd0,  1'b0, 16'h1234, 16'hFFFF, 24'h000064, GOAL_PRICE,   24'h000000,
      1'b1, STAT_OK,   6'd2},
    '{FUNC_LOAD,   6'd0,  1'b0, 16'hFFFF, 16'h0007, 24'h000064, GOAL_PRICE,   24'h000000,
      1'b1, STAT_OK,   6'd3},
    '{FUNC_SELECT, 6'd0,  1'b0, 16'h0000, 16'h0000, 24'h000000, GOAL_PRICE,   24'hFFFFFF,
      1'b0, STAT_OK,   6'd0},
    '{FUNC_SELECT, 6'd0,  1'b0, 16'h0000, 16'h0000, 24'h000000, GOAL_SPEED,   24'hFFFFFF,
      1'b0, STAT_OK,   6'd0},
    '{FUNC_SELECT, 6'd0,  1'b0, 16'h0000, 16'h0000, 24'h000000, GOAL_QUALITY, 24'hFFFFFF,
      1'b0, STAT_OK,   6'd0},
    '{FUNC_SELECT, 6'd0,  1'b0, 16'h0000, 16'h0000, 24'h000000, GOAL_FIRST,   24'hFFFFFF,
      1'b0, STAT_OK,   6'd0},
    '{FUNC_SELECT, 6'd0,  1'b0, 16'h0000, 16'h0000, 24'h000000, GOAL_QUALITY, 24'h000063,
      1'b0, STAT_OK,   6'd0},
    '{FUNC_SELECT, 6'd0,  1'b0, 16'h0000, 16'h0000, 24'h000000, GOAL_SPEED,   24'h000064,
      1'b0, STAT_OK,   6'd0},
    '{FUNC_MARK,   6'd0,  1'b1, 16'h0000, 16'h0000, 24'h000000, GOAL_PRICE,   24'h000000,
      1'b1, STAT_OK,   6'd0},
    '{FUNC_SELECT, 6'd0,  1'b0, 16'h0000, 16'h0000, 24'h000000, GOAL_PRICE,   24'h000000,
      1'b0, STAT_OK,   6'd0},
    '{FUNC_SELECT, 6'd0,  1'b0, 16'h0000, 16'h0000, 24'h000000, GOAL_FIRST,   24'h000064,
      1'b0, STAT_OK,   6'd0},
    '{FUNC_MARK,   6'd2,  1'b1, 16'h0000, 16'h0000, 24'h000000, GOAL_PRICE,   24'h000000,
      1'b1, STAT_OK,   6'd2},
    '{FUNC_SELECT, 6'd0,  1'b0, 16'h0000, 16'h0000, 24'h000000, GOAL_SPEED,   24'hFFFFFE,
      1'b0, STAT_OK,   6'd0},
    '{FUNC_CLEAR,  6'd0,  1'b0, 16'h0000, 16'h0000, 24'h000000, GOAL_PRICE,   24'h000000,
      1'b1, STAT_OK,   6'd0},
    '{FUNC_SELECT, 6'd0,  1'b0, 16'h0000, 16'h0000, 24'h000000, GOAL_PRICE,   24'hFFFFFF,
      1'b1, STAT_NONE, 6'd0},
    '{FUNC_LOAD,   6'd0,  1'b0, 16'h0005, 16'h0005, 24'hFFFFFF, GOAL_PRICE,   24'h000000,
      1'b1, STAT_OK,   6'd0},
    '{FUNC_SELECT, 6'd0,  1'b0, 16'h0000, 16'h0000, 24'h000000, GOAL_QUALITY, 24'hFFFFFF,
      1'b0, STAT_OK,   6'd0}
  };

  // Update the table copy and work out the response of one request.
  function automatic pick_t apply_request(request_t r);
    pick_t p;
    bit    found;
    bit    wins;
    int    best;
    p.status = STAT_OK;
    p.index  = '0;
    found    = 1'b0;
    best     = 0;
    case (r.func)
      FUNC_LOAD: begin
        if (loaded >= MaxEntries) begin
          p.status = STAT_FULL;
        end else begin
          quality_tab[loaded] = r.quality;
          speed_tab[loaded]   = r.speed;
          price_tab[loaded]   = r.price;
          busy_tab[loaded]    = 1'b0;
          p.index             = IndexW'(loaded);
          loaded++;
        end
      end
      FUNC_MARK: begin
        busy_tab[r.index] = r.busy;
        p.index           = r.index;
      end
      FUNC_SELECT: begin
        for (int i = 0; i < loaded; i++) begin
          if (!busy_tab[i] && price_tab[i] <= r.budget) begin
            case (r.goal)
              GOAL_PRICE:   wins = price_tab[i] < price_tab[best];
              GOAL_SPEED:   wins = speed_tab[i] > speed_tab[best];
              GOAL_QUALITY: wins = quality_tab[i] > quality_tab[best];
              default:      wins = 1'b0;
            endcase
            if (!found || wins) best = i;
            found = 1'b1;
          end
        end
        if (found) p.index = IndexW'(best);
        else p.status = STAT_NONE;
      end
      default: loaded = 0;
    endcase
    return p;
  endfunction

  // Mostly back to back, some short gaps, a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [15:0] rand_score();
    if ($urandom_range(0, 2) == 0) return 16'($urandom_range(0, 7));
    return 16'($urandom);
  endfunction

  function automatic request_t rand_request(func_e f);
    request_t r;
    r.func    = f;
    r.index   = IndexW'($urandom);
    r.busy    = 1'($urandom);
    r.quality = rand_score();
    r.speed   = rand_score();
    r.price   = ($urandom_range(0, 2) == 0) ? PriceW'($urandom_range(0, 15))
                                            : PriceW'($urandom);
    r.goal    = goal_e'($urandom_range(0, 3));
    case ($urandom_range(0, 5))
      0:       r.budget = '0;
      1:       r.budget = PriceMax;
      2, 3:    r.budget = (loaded > 0) ? price_tab[$urandom_range(0, loaded - 1)]
                                       : PriceW'($urandom_range(0, 15));
      default: r.budget = PriceW'($urandom);
    endcase
    // Aim marks mostly at loaded entries.
    if (f == FUNC_MARK && loaded > 0 && $urandom_range(0, 3) != 0)
      r.index = IndexW'($urandom_range(0, loaded - 1));
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // Present one request, hold it until the transaction, then predict.
  task automatic send_request(request_t r, bit typed, pick_t typed_pick);
    int unsigned gap;
    pick_t       p;
    gap = pick_gap();
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {7'b0, r.budget, r.goal, r.price, r.speed, r.quality, r.busy, r.index};
    s_func  <= r.func;
    do @(posedge clk_i); while (!s_ready);
    p = apply_request(r);
    pending_picks.push_back(typed ? typed_pick : p);
    sent++;
  endtask

  task automatic wait_drain();
    s_valid <= 1'b0;
    while (pending_picks.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_random(func_e f);
    send_request(rand_request(f), 1'b0, '0);
  endtask

  function automatic func_e rand_func();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 35) return FUNC_LOAD;
    if (roll < 55) return FUNC_MARK;
    if (roll < 95) return FUNC_SELECT;
    return FUNC_CLEAR;
  endfunction

  // Stimulus
  initial begin
    request_t    r;
    pick_t       tp;
    int unsigned scen;
    s_valid    <= 1'b0;
    s_data     <= '0;
    s_func     <= FUNC_LOAD;
    rst_ni     <= 1'b0;
    mismatches = 0;
    sent       = 0;
    loaded     = 0;
    no_idle    = 1'b0;
    scen       = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[k]) begin
      r  = '{dir_rows[k].func, dir_rows[k].index, dir_rows[k].busy, dir_rows[k].quality,
             dir_rows[k].speed, dir_rows[k].price, dir_rows[k].goal, dir_rows[k].budget};
      tp = '{dir_rows[k].status, dir_rows[k].chosen};
      send_request(r, dir_rows[k].typed, tp);
    end
    wait_drain();

    while (sent < RandomItems + dir_rows.size()) begin
      no_idle = ($urandom_range(0, 4) == 0);
      if (scen % 15 == 3) begin
        // Fill past capacity, then work on a full table.
        send_random(FUNC_CLEAR);
        repeat (MaxEntries + $urandom_range(1, 3)) send_random(FUNC_LOAD);
        repeat ($urandom_range(6, 12))
          send_random(($urandom_range(0, 2) == 0) ? FUNC_MARK : FUNC_SELECT);
      end else begin
        if ($urandom_range(0, 3) != 0) send_random(FUNC_CLEAR);
        repeat ($urandom_range(4, 24)) send_random(rand_func());
      end
      if ($urandom_range(0, 3) == 0) wait_drain();
      scen++;
    end

    wait_drain();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Receiver: random backpressure, compare each response with the oldest pick
  initial begin
    int unsigned stall;
    pick_t       want;
    stall = 0;
    m_ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_valid && m_ready) begin
        if (pending_picks.size() == 0) begin
          report_mismatch("unexpected response, status", m_status, -1);
        end else begin
          want = pending_picks.pop_front();
          if (m_status != want.status) report_mismatch("status", m_status, want.status);
          if (m_data[IndexW-1:0] != want.index)
            report_mismatch("chosen_index", m_data[IndexW-1:0], want.index);
        end
      end
      if (stall > 0) begin
        m_ready <= 1'b0;
        stall--;
      end else begin
        m_ready <= 1'b1;
        if ($urandom_range(0, 2) == 0) stall = pick_gap();
      end
    end
  end

  // Watchdog: give up after a long stretch without any transaction
  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
      else quiet++;
      if (quiet >= WatchdogMax) begin
        $display("TIMEOUT at %0t: no transaction for %0d cycles", $realtime, quiet);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

endmodule

[sim.f]
hw/rtl/eebs_pkg.sv
hw/rtl/eebs_ram.sv
hw/rtl/eebs_cmp.sv
hw/rtl/eligible_entry_best_select.sv
bench/eligible_entry_best_select_tb.sv
